/* sv/rp2p_pkg.sv */
// ----------------------------------------------------------------------------
// rp2p_pkg: shared constants and types for the range pixel to point core
// Angle constants (2^-16 degree), CORDIC arc table, register codes, and the
// side-band record that travels down the pipeline.
// ----------------------------------------------------------------------------
package rp2p_pkg;

  localparam int ROWS         = 64;
  localparam int DEG_FULL     = 23592960;
  localparam int DEG_HALF     = 11796480;
  localparam int DEG_QUARTER  = 5898240;
  localparam int AZ_OFFSET    = 60 * 65536;
  localparam int EL_STEP      = 25 * 65536 / (2 * ROWS);
  localparam int CORDIC_START = 652032874;
  localparam int CORDIC_STEPS = 23;
  localparam int DIV_STEPS    = 8;
  localparam int POS_LIMIT    = 16776960;

  // Largest biased azimuth sum and the number of full turns it can hold
  localparam int AZ_V_MAX  = ((2 ** 20 - 1) * (2 * 255 + 1) + 1) / 2 + DEG_FULL - AZ_OFFSET;
  localparam int WRAP_MAX  = AZ_V_MAX / DEG_FULL;
  localparam int AZ_BIAS   = DEG_FULL - AZ_OFFSET;

  localparam int XW  = 33;   // CORDIC vector width, Q30
  localparam int RW  = 26;   // residual angle width
  localparam int VW  = 29;   // biased azimuth width
  localparam int PW  = 50;   // distance times trig product
  localparam int TW  = 34;   // horizontal range, Q16 cm
  localparam int PXW = TW + XW;
  localparam int POSW = 25;

  localparam int ATAN [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef enum logic [1:0] {
    REG_ANGLE_STEP,
    REG_MAX_DIST,
    REG_MIN_DIST,
    REG_MAX_INT
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] dist_cm;
    logic        bad;
    logic        flip;
    logic        sat;
    logic [23:0] rem;
    logic [7:0]  quo;
  } side_t;

  function automatic logic signed [POSW-1:0] clamp_pos(input logic signed [31:0] v);
    logic signed [POSW-1:0] r;
    if (v > 32'sd16776960) begin
      r = POSW'(POS_LIMIT);
    end else if (v < -32'sd16776960) begin
      r = -POSW'(POS_LIMIT);
    end else begin
      r = v[POSW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/range_pixel_to_point_core.sv */
// ----------------------------------------------------------------------------
// range_pixel_to_point_core: range-image pixel to 3D point projection
// Elevation from row, azimuth from column, sine and cosine by two pipelined
// CORDICs, projection multipliers, and a pipelined intensity divider.
// ----------------------------------------------------------------------------
//
//  channel   | direction | transfer rule              | contents
//  ----------+-----------+----------------------------+---------------------------
//  s_axis    | in        | tvalid & tready            | row, column, distance, raw
//  m_axis    | out       | tvalid & tready            | x, y, z, intensity; invalid
//  cfg       | in        | cfg_we_i at clock edge     | index, data
//
//  One transaction per cycle sustained while m_axis does not stall; the pipeline
//  holds the 23 CORDIC iterations (one register stage each) plus wrap, fold and
//  the two chained projection multipliers.
//  rst_ni clears all stage valid bits and loads the register reset values.
//  A stall at m_axis freezes every stage at once; s_axis_tready_o follows
//  the output register, so the input is taken while a result waits only if
//  the output is free or being taken in the same cycle.
//
module range_pixel_to_point_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] row, [13:6] column, [29:14] distance_cm, [45:30] intensity_raw
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [24:0] x_pos, [49:25] y_pos, [74:50] z_pos, [82:75] intensity_out
  output logic [87:0] m_axis_tdata_o,
  // [0] point_invalid
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);
  import rp2p_pkg::*;

  // Configuration registers
  logic [19:0] step_q;
  logic [15:0] maxd_q, mind_q, maxi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 20'd24576;
      maxd_q <= 16'hFFFF;
      mind_q <= 16'd0;
      maxi_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ANGLE_STEP: step_q <= cfg_data_i;
        REG_MAX_DIST:   maxd_q <= cfg_data_i[15:0];
        REG_MIN_DIST:   mind_q <= cfg_data_i[15:0];
        REG_MAX_INT:    maxi_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output is free or taken
  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- Stage 1: elevation, azimuth product, intensity numerator, range check
  logic [5:0]  row_in;
  logic [7:0]  col_in;
  logic [15:0] dist_in, raw_in;
  assign row_in  = s_axis_tdata_i[5:0];
  assign col_in  = s_axis_tdata_i[13:6];
  assign dist_in = s_axis_tdata_i[29:14];
  assign raw_in  = s_axis_tdata_i[45:30];

  logic signed [7:0]    rt;
  logic signed [RW-1:0] el_d;
  logic [28:0]          azp_d;
  logic [23:0]          num_d;
  side_t                side1_d;

  always_comb begin
    rt      = 8'sd63 - $signed({1'b0, row_in, 1'b0});
    el_d    = RW'(rt) * RW'(EL_STEP);
    azp_d   = {9'b0, step_q} * {20'b0, col_in, 1'b1};
    num_d   = {8'b0, raw_in} * 24'd255;
    side1_d = '0;
    side1_d.dist_cm = dist_in;
    side1_d.bad  = (dist_in > maxd_q) || (dist_in < mind_q);
    side1_d.rem  = num_d;
  end

  logic                 v1_q, v2_q, v3_q;
  logic signed [RW-1:0] el1_q, el2_q, el3_q;
  logic [28:0]          azp1_q;
  logic [VW-1:0]        azv2_q;
  logic [24:0]          azr3_q;
  side_t                sd1_q, sd2_q, sd3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      el1_q  <= el_d;
      azp1_q <= azp_d;
      sd1_q  <= side1_d;
    end
  end

  // ---------------- Stage 2: round half step, bias into positive range, intensity saturation check
  logic [29:0]   azp_inc;
  logic [VW-1:0] azv_d;
  side_t         side2_d;
  always_comb begin
    azp_inc = {1'b0, azp1_q} + 30'd1;
    azv_d   = azp_inc[29:1] + VW'(AZ_BIAS);
    side2_d = sd1_q;
    side2_d.sat = sd1_q.rem >= {maxi_q, 8'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      el2_q  <= el1_q;
      azv2_q <= azv_d;
      sd2_q  <= side2_d;
    end
  end

  // ---------------- Stage 3: remove whole turns
  logic [24:0] azr_d;
  always_comb begin
    azr_d = azv2_q[24:0];
    for (int k = 1; k <= WRAP_MAX; k++) begin
      if (azv2_q >= VW'(k * DEG_FULL)) begin
        azr_d = 25'(azv2_q - VW'(k * DEG_FULL));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      el3_q  <= el2_q;
      azr3_q <= azr_d;
      sd3_q  <= sd2_q;
    end
  end

  // ---------------- Stage 4: fold into [-90, 90], start both CORDICs
  logic signed [RW-1:0] fa0, fa1;
  logic                 ffl;
  always_comb begin
    fa0 = $signed({1'b0, azr3_q}) - ((azr3_q >= 25'(DEG_HALF)) ? RW'(DEG_FULL) : RW'(0));
    fa1 = fa0;
    ffl = 1'b0;
    if (fa0 > RW'(DEG_QUARTER)) begin
      fa1 = fa0 - RW'(DEG_HALF);
      ffl = 1'b1;
    end else if (fa0 < -RW'(DEG_QUARTER)) begin
      fa1 = fa0 + RW'(DEG_HALF);
      ffl = 1'b1;
    end
  end

  logic signed [XW-1:0] ex_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] ey_q [CORDIC_STEPS+1];
  logic signed [RW-1:0] er_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] ax_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] ay_q [CORDIC_STEPS+1];
  logic signed [RW-1:0] ar_q [CORDIC_STEPS+1];
  side_t                cs_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] cv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q[0] <= XW'(CORDIC_START);
      ey_q[0] <= '0;
      er_q[0] <= el3_q;
      ax_q[0] <= XW'(CORDIC_START);
      ay_q[0] <= '0;
      ar_q[0] <= fa1;
      cs_q[0] <= '{dist_cm: sd3_q.dist_cm, bad: sd3_q.bad, flip: ffl, sat: sd3_q.sat,
                   rem: sd3_q.rem, quo: sd3_q.quo};
    end
  end

  // ---------------- CORDIC iterations, one per stage; divider rides along
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] ex_d, ey_d, ax_d, ay_d;
    logic signed [RW-1:0] er_d, ar_d;
    side_t                s_d;

    always_comb begin
      if (er_q[i] >= 0) begin
        ex_d = ex_q[i] - (ey_q[i] >>> i);
        ey_d = ey_q[i] + (ex_q[i] >>> i);
        er_d = er_q[i] - RW'(ATAN[i]);
      end else begin
        ex_d = ex_q[i] + (ey_q[i] >>> i);
        ey_d = ey_q[i] - (ex_q[i] >>> i);
        er_d = er_q[i] + RW'(ATAN[i]);
      end
      if (ar_q[i] >= 0) begin
        ax_d = ax_q[i] - (ay_q[i] >>> i);
        ay_d = ay_q[i] + (ax_q[i] >>> i);
        ar_d = ar_q[i] - RW'(ATAN[i]);
      end else begin
        ax_d = ax_q[i] + (ay_q[i] >>> i);
        ay_d = ay_q[i] - (ax_q[i] >>> i);
        ar_d = ar_q[i] + RW'(ATAN[i]);
      end
    end

    if (i < DIV_STEPS) begin : g_div
      logic [23:0] dm;
      always_comb begin
        dm  = {8'b0, maxi_q} << (DIV_STEPS - 1 - i);
        s_d = cs_q[i];
        if (cs_q[i].rem >= dm) begin
          s_d.rem = cs_q[i].rem - dm;
          s_d.quo[DIV_STEPS-1-i] = 1'b1;
        end
      end
    end else begin : g_nodiv
      assign s_d = cs_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_q[i+1] <= ex_d;
        ey_q[i+1] <= ey_d;
        er_q[i+1] <= er_d;
        ax_q[i+1] <= ax_d;
        ay_q[i+1] <= ay_d;
        ar_q[i+1] <= ar_d;
        cs_q[i+1] <= s_d;
      end
    end
  end

  // ---------------- Undo the azimuth fold
  logic signed [XW-1:0] se_q, ce_q, sa_q, ca_q;
  side_t                sf_q;
  logic                 vf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q <= ey_q[CORDIC_STEPS];
      ce_q <= ex_q[CORDIC_STEPS];
      sa_q <= cs_q[CORDIC_STEPS].flip ? -ay_q[CORDIC_STEPS] : ay_q[CORDIC_STEPS];
      ca_q <= cs_q[CORDIC_STEPS].flip ? -ax_q[CORDIC_STEPS] : ax_q[CORDIC_STEPS];
      sf_q <= cs_q[CORDIC_STEPS];
    end
  end

  // ---------------- M1: distance times elevation sine and cosine
  logic signed [PW-1:0] pdc_q, pds_q;
  logic signed [XW-1:0] sa1_q, ca1_q;
  side_t                sm1_q;
  logic                 vm1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdc_q <= $signed({1'b0, sf_q.dist_cm}) * ce_q;
      pds_q <= $signed({1'b0, sf_q.dist_cm}) * se_q;
      sa1_q <= sa_q;
      ca1_q <= ca_q;
      sm1_q <= sf_q;
    end
  end

  // ---------------- M2: round horizontal range and height
  logic signed [PW-1:0]   tr, zr;
  logic signed [TW-1:0]   t2_q;
  logic signed [POSW-1:0] z2_q;
  logic signed [XW-1:0]   sa2_q, ca2_q;
  side_t                  sm2_q;
  logic                   vm2_q;

  always_comb begin
    tr = pdc_q + (PW'(1) <<< 13);
    zr = pds_q + (PW'(1) <<< 21);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_q  <= tr[TW+13:14];
      z2_q  <= clamp_pos(32'($signed(zr[PW-1:22])));
      sa2_q <= sa1_q;
      ca2_q <= ca1_q;
      sm2_q <= sm1_q;
    end
  end

  // ---------------- M3: range times azimuth sine and cosine
  logic signed [PXW-1:0]  px_q, py_q;
  logic signed [POSW-1:0] z3_q;
  side_t                  sm3_q;
  logic                   vm3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= t2_q * sa2_q;
      py_q  <= t2_q * ca2_q;
      z3_q  <= z2_q;
      sm3_q <= sm2_q;
    end
  end

  // ---------------- Output register: round, clamp, zero the payload of invalid points
  logic signed [PXW-1:0]  xr, yr;
  logic signed [POSW-1:0] x_d, y_d;
  logic signed [POSW-1:0] x_q, y_q, z_q;
  logic [7:0]             inten_q;
  logic                   bad_q;

  always_comb begin
    xr  = px_q + (PXW'(1) <<< 37);
    yr  = py_q + (PXW'(1) <<< 37);
    x_d = clamp_pos(32'($signed(xr[PXW-1:38])));
    y_d = clamp_pos(32'($signed(yr[PXW-1:38])));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= sm3_q.bad ? '0 : x_d;
      y_q     <= sm3_q.bad ? '0 : y_d;
      z_q     <= sm3_q.bad ? '0 : z3_q;
      inten_q <= sm3_q.bad ? 8'd0 : (sm3_q.sat ? 8'd255 : sm3_q.quo);
      bad_q   <= sm3_q.bad;
    end
  end

  // ---------------- Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      cv_q    <= '0;
      vf_q    <= 1'b0;
      vm1_q   <= 1'b0;
      vm2_q   <= 1'b0;
      vm3_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      cv_q    <= {cv_q[CORDIC_STEPS-1:0], v3_q};
      vf_q    <= cv_q[CORDIC_STEPS];
      vm1_q   <= vf_q;
      vm2_q   <= vm1_q;
      vm3_q   <= vm2_q;
      out_v_q <= vm3_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'b0, inten_q, z_q, y_q, x_q};
  assign m_axis_tuser_o  = bad_q;

  // ---------------- Assertions
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("invalid point carries nonzero payload");

  a_last_stage_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm3_q && en) |=> m_axis_tvalid_o)
    else $error("result lost between last stage and output");

  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[24:0]) <= 25'sd16776960 &&
                         $signed(m_axis_tdata_o[24:0]) >= -25'sd16776960))
    else $error("x outside clamp range");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(cv_q))
    else $error("pipeline moved during stall");

endmodule
